FILE: hdl/intra_block_reconstruct_defines.svh
// Assertion macros shared by the intra block reconstruction RTL.
// Depends on a clock named i_clk and a synchronous active-low reset named i_rst_n.
`ifndef INTRA_BLOCK_RECONSTRUCT_DEFINES_SVH
`define INTRA_BLOCK_RECONSTRUCT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IBR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ibr_pkg.sv
// Types and constants for the intra block reconstruction block.
// Has no dependencies; used by ibr_predict and intra_block_reconstruct.
`timescale 1ns / 1ps

package ibr_pkg;

    localparam logic [7:0]  PIX_MID = 8'd128;
    localparam logic [63:0] ROW_MID = {8{8'h80}};

    typedef enum logic [1:0] {
        MODE_DC   = 2'd0,
        MODE_VERT = 2'd1,
        MODE_HORZ = 2'd2,
        MODE_DIAG = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [8:0] residual;
        t_mode             mode;
        logic [7:0]        block_row;
        logic [7:0]        block_col;
        logic [2:0]        pix_row;
        logic [2:0]        pix_col;
    } t_in_req;

    typedef struct packed {
        logic [7:0] pixel;
        logic       block_done;
    } t_out_req;

    typedef struct packed {
        logic [63:0] top;
        logic [63:0] left;
        logic [7:0]  corner;
        logic [7:0]  dc;
    } t_refs;

    function automatic logic [7:0] get_pix(input logic [63:0] row, input logic [2:0] idx);
        get_pix = row[{idx, 3'b000} +: 8];
    endfunction

endpackage

FILE: hdl/ibr_predict.sv
// Reference selection at block start and per-pixel prediction for all four modes.
// Depends on ibr_pkg.
`timescale 1ns / 1ps

module ibr_predict import ibr_pkg::*; (
    input  t_in_req     i_req,
    input  logic        i_start,
    input  t_refs       i_held,
    input  logic [63:0] i_line_row,
    input  logic [63:0] i_right_col,
    input  logic [7:0]  i_prev_top_last,
    output t_refs       o_refs,
    output logic [7:0]  o_pred
);

    t_refs       w_new;
    logic [11:0] w_sum;
    logic [2:0]  w_x;
    logic [2:0]  w_y;
    logic [2:0]  w_dx;
    logic [2:0]  w_dy;

    assign w_x  = i_req.pix_col;
    assign w_y  = i_req.pix_row;
    assign w_dx = w_x - w_y - 3'd1;
    assign w_dy = w_y - w_x - 3'd1;

    always_comb begin
        w_new.top    = (i_req.block_row != 8'd0) ? i_line_row : ROW_MID;
        w_new.left   = (i_req.block_col != 8'd0) ? i_right_col : ROW_MID;
        w_new.corner = (i_req.block_row != 8'd0 && i_req.block_col != 8'd0) ?
                       i_prev_top_last : PIX_MID;
        w_sum = 12'd0;
        for (int i = 0; i < 8; i++) begin
            w_sum = w_sum + 12'(get_pix(w_new.top, 3'(i)))
                          + 12'(get_pix(w_new.left, 3'(i)));
        end
        w_new.dc = w_sum[11:4];
    end

    assign o_refs = i_start ? w_new : i_held;

    always_comb begin
        unique case (i_req.mode)
            MODE_DC:   o_pred = o_refs.dc;
            MODE_VERT: o_pred = get_pix(o_refs.top, w_x);
            MODE_HORZ: o_pred = get_pix(o_refs.left, w_y);
            MODE_DIAG: begin
                if (w_x > w_y) begin
                    o_pred = get_pix(o_refs.top, w_dx);
                end else if (w_x == w_y) begin
                    o_pred = o_refs.corner;
                end else begin
                    o_pred = get_pix(o_refs.left, w_dy);
                end
            end
            default:   o_pred = o_refs.dc;
        endcase
    end

endmodule

FILE: hdl/intra_block_reconstruct.sv
// Top level of the 8x8 intra prediction and reconstruction block.
// Depends on ibr_pkg, ibr_predict and intra_block_reconstruct_defines.svh.
//
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   i_in_data  (t_in_req)
// output   out        o_out_valid / i_out_stall o_out_data (t_out_req)
//
// One pixel request is taken per cycle unless stalled; the output register holds its result.
// The line store read is issued as the request is taken and the read data is registered.
// Prediction and the residual add sit between the input stage and the output register.
// Reset clears the reference registers to 128; the line store is not cleared.
// A stalled output register holds the input stage, which then stalls the input channel.
`timescale 1ns / 1ps
`include "intra_block_reconstruct_defines.svh"

module intra_block_reconstruct import ibr_pkg::*; #(
    parameter int MAX_BLOCKS_PER_ROW = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    localparam int AW = (MAX_BLOCKS_PER_ROW > 1) ? $clog2(MAX_BLOCKS_PER_ROW) : 1;

    logic [AW-1:0] w_mod_tab [256];

    logic [63:0]   r_line_mem [MAX_BLOCKS_PER_ROW];
    logic [63:0]   r_rd_row;
    logic          r_fwd_en;
    logic [2:0]    r_fwd_col;
    logic [7:0]    r_fwd_pix;

    logic          r_s1_valid;
    t_in_req       r_s1_req;
    logic [AW-1:0] r_s1_idx;

    t_refs         r_held;
    logic [63:0]   r_right_col;
    logic [7:0]    r_prev_top_last;

    logic          r_out_valid;
    t_out_req      r_out_data;

    logic          w_in_acc;
    logic          w_adv;
    logic [AW-1:0] w_rd_idx;
    logic          w_wr_en;
    logic [63:0]   w_line_row;
    logic          w_start;
    t_refs         w_refs;
    logic [7:0]    w_pred;
    logic [7:0]    w_pix;

    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tab[g] = AW'(g % MAX_BLOCKS_PER_ROW);
    end

    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_rd_idx   = w_mod_tab[i_in_data.block_col];
    assign w_start    = (r_s1_req.pix_row == 3'd0) && (r_s1_req.pix_col == 3'd0);
    assign w_wr_en    = w_adv && (r_s1_req.pix_row == 3'd7);

    always_comb begin
        w_line_row = r_rd_row;
        if (r_fwd_en) begin
            w_line_row[{r_fwd_col, 3'b000} +: 8] = r_fwd_pix;
        end
    end

    ibr_predict u_predict (
        .i_req           (r_s1_req),
        .i_start         (w_start),
        .i_held          (r_held),
        .i_line_row      (w_line_row),
        .i_right_col     (r_right_col),
        .i_prev_top_last (r_prev_top_last),
        .o_refs          (w_refs),
        .o_pred          (w_pred)
    );

    assign w_pix = w_pred + r_s1_req.residual[7:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_line_mem[r_s1_idx][{r_s1_req.pix_col, 3'b000} +: 8] <= w_pix;
        end
        if (w_in_acc) begin
            r_rd_row <= r_line_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_en   <= w_wr_en && (r_s1_idx == w_rd_idx);
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_req  <= i_in_data;
            r_s1_idx  <= w_rd_idx;
            r_fwd_col <= r_s1_req.pix_col;
            r_fwd_pix <= w_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held          <= '{top: ROW_MID, left: ROW_MID, corner: PIX_MID, dc: PIX_MID};
            r_right_col     <= ROW_MID;
            r_prev_top_last <= PIX_MID;
        end else if (w_adv) begin
            r_held <= w_refs;
            if (w_start) begin
                r_prev_top_last <= w_refs.top[63:56];
            end
            if (r_s1_req.pix_col == 3'd7) begin
                r_right_col[{r_s1_req.pix_row, 3'b000} +: 8] <= w_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data.pixel      <= w_pix;
            r_out_data.block_done <= (r_s1_req.pix_row == 3'd7) && (r_s1_req.pix_col == 3'd7);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `IBR_ASSERT_SAME(a_stall_needs_item, o_in_stall, r_s1_valid && r_out_valid,
                     "Input stalled without a held request.")
    `IBR_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid,
                     "Advanced request did not reach the output register.")
    `IBR_ASSERT_NEXT(a_fwd_captured, w_in_acc && w_wr_en && (r_s1_idx == w_rd_idx), r_fwd_en,
                     "Line store write was not forwarded to the new request.")
    `IBR_ASSERT_SAME(a_left_edge_mid,
                     r_s1_valid && w_start && (r_s1_req.block_col == 8'd0),
                     (w_refs.left == ROW_MID) && (w_refs.corner == PIX_MID),
                     "Left picture edge did not use mid-gray references.")

endmodule
